// ----- src/tcp_connection_tracker_core_defines.svh -----
// Assertion macros shared by the connection tracker RTL.
// Depends on nothing; the including module provides clk_i and rst_ni.
`ifndef TCP_CONNECTION_TRACKER_CORE_DEFINES_SVH
`define TCP_CONNECTION_TRACKER_CORE_DEFINES_SVH

// Same-cycle implication, checked on every rising edge outside reset.
`define TCT_ASSERT_SAME(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, checked on every rising edge outside reset.
`define TCT_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ----- src/tct_pkg.sv -----
// Shared types and constants of the TCP connection tracker.
// Depends on nothing; used by tct_cell and tcp_connection_tracker_core.
package tct_pkg;

  localparam int unsigned TableEntries = 64;

  // TCP flag bit positions.
  localparam int unsigned FlagFin = 0;
  localparam int unsigned FlagSyn = 1;
  localparam int unsigned FlagRst = 2;
  localparam int unsigned FlagAck = 4;

  // Entry status bits.
  localparam logic [7:0] StSyn     = 8'h01;
  localparam logic [7:0] StSynAck  = 8'h02;
  localparam logic [7:0] StEst     = 8'h04;
  localparam logic [7:0] StFinSrc  = 8'h08;
  localparam logic [7:0] StFinDst  = 8'h10;
  localparam logic [7:0] StSrcDone = 8'h20;
  localparam logic [7:0] StDstDone = 8'h40;
  localparam logic [7:0] StGrab    = 8'h80;

  // Event codes reported in event_res.
  localparam logic [3:0] EvUpdated  = 4'd0;
  localparam logic [3:0] EvAttempt  = 4'd1;
  localparam logic [3:0] EvGrabbed  = 4'd2;
  localparam logic [3:0] EvEstab    = 4'd3;
  localparam logic [3:0] EvFinished = 4'd4;
  localparam logic [3:0] EvReset    = 4'd5;
  localparam logic [3:0] EvSynAckIn = 4'd6;
  localparam logic [3:0] EvIgnored  = 4'd7;
  localparam logic [3:0] EvFull     = 4'd8;
  localparam logic [3:0] EvSpotted  = 4'd9;

  // Configuration register indexes.
  localparam int unsigned CfgIdxW = 2;
  localparam logic [CfgIdxW-1:0] CfgGrabEnable    = 2'd0;
  localparam logic [CfgIdxW-1:0] CfgGrabThreshold = 2'd1;

  typedef struct packed {
    logic [31:0] src_addr;
    logic [31:0] dst_addr;
    logic [15:0] src_port;
    logic [15:0] dst_port;
    logic [7:0]  tcp_flags;
    logic [31:0] src_seq;
    logic [31:0] dst_seq;
    logic [31:0] timestamp;
  } in_item_t;

  typedef struct packed {
    logic [3:0] event_res;
    logic [5:0] entry_index;
    logic       notify;
    logic [7:0] entry_status;
  } out_item_t;

  // Search token that walks the cell chain, one cell per cycle.
  typedef struct packed {
    logic       valid;
    logic       match_found;
    logic       free_found;
    logic [7:0] status;
    logic [7:0] ack_count;
    logic       fwd;
    logic       sa_eq_dst;
  } tok_t;

  typedef enum logic [1:0] {
    WR_ALLOC,
    WR_UPDATE,
    WR_REMOVE
  } wr_op_e;

  // Write broadcast to all cells; the addressed cell applies it.
  typedef struct packed {
    logic        valid;
    wr_op_e      op;
    logic [7:0]  status;
    logic [7:0]  ack_count;
    logic [31:0] fwd_seq;
    logic [31:0] rev_seq;
    logic [31:0] last_time;
  } wr_t;

endpackage

// ----- src/tct_cell.sv -----
// One table slot of the connection tracker and its stage of the search chain.
// Depends on tct_pkg.
module tct_cell #(
  parameter int unsigned IdxW    = 6,
  parameter int unsigned CellIdx = 0
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  tct_pkg::in_item_t  hdr_i,
  input  tct_pkg::tok_t      tok_i,
  input  logic [IdxW-1:0]    match_idx_i,
  input  logic [IdxW-1:0]    free_idx_i,
  output tct_pkg::tok_t      tok_o,
  output logic [IdxW-1:0]    match_idx_o,
  output logic [IdxW-1:0]    free_idx_o,
  input  tct_pkg::wr_t       wr_i,
  input  logic [IdxW-1:0]    wr_idx_i
);

  localparam logic [IdxW-1:0] MyIdx = IdxW'(CellIdx);

  logic        valid_q;
  logic [31:0] src_addr_q, dst_addr_q;
  logic [15:0] src_port_q, dst_port_q;
  logic [7:0]  status_q, ack_count_q;
  logic [31:0] start_time_q, last_time_q, fwd_seq_q, rev_seq_q;

  tct_pkg::tok_t   tok_d, tok_q;
  logic [IdxW-1:0] match_idx_d, match_idx_q, free_idx_d, free_idx_q;
  logic            hit, take_match, take_free, wr_hit;

  assign hit = valid_q &&
    ((src_addr_q == hdr_i.src_addr && dst_addr_q == hdr_i.dst_addr &&
      src_port_q == hdr_i.src_port && dst_port_q == hdr_i.dst_port) ||
     (src_addr_q == hdr_i.dst_addr && dst_addr_q == hdr_i.src_addr &&
      src_port_q == hdr_i.dst_port && dst_port_q == hdr_i.src_port));

  assign take_match = tok_i.valid && !tok_i.match_found && hit;
  assign take_free  = tok_i.valid && !tok_i.free_found && !valid_q;
  assign wr_hit     = wr_i.valid && (wr_idx_i == MyIdx);

  always_comb begin
    tok_d       = tok_i;
    match_idx_d = match_idx_i;
    free_idx_d  = free_idx_i;
    if (take_match) begin
      tok_d.match_found = 1'b1;
      tok_d.status      = status_q;
      tok_d.ack_count   = ack_count_q;
      tok_d.fwd         = (hdr_i.src_addr == src_addr_q);
      tok_d.sa_eq_dst   = (hdr_i.src_addr == dst_addr_q);
      match_idx_d       = MyIdx;
    end
    if (take_free) begin
      tok_d.free_found = 1'b1;
      free_idx_d       = MyIdx;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
      tok_q   <= '0;
    end else begin
      tok_q <= tok_d;
      if (wr_hit) begin
        unique case (wr_i.op)
          tct_pkg::WR_ALLOC:  valid_q <= 1'b1;
          tct_pkg::WR_REMOVE: valid_q <= 1'b0;
          default:            valid_q <= valid_q;
        endcase
      end
    end
  end

  always_ff @(posedge clk_i) begin
    match_idx_q <= match_idx_d;
    free_idx_q  <= free_idx_d;
    if (wr_hit && wr_i.op != tct_pkg::WR_REMOVE) begin
      status_q    <= wr_i.status;
      ack_count_q <= wr_i.ack_count;
      last_time_q <= wr_i.last_time;
      fwd_seq_q   <= wr_i.fwd_seq;
      rev_seq_q   <= wr_i.rev_seq;
      if (wr_i.op == tct_pkg::WR_ALLOC) begin
        src_addr_q   <= hdr_i.src_addr;
        dst_addr_q   <= hdr_i.dst_addr;
        src_port_q   <= hdr_i.src_port;
        dst_port_q   <= hdr_i.dst_port;
        start_time_q <= wr_i.last_time;
      end
    end
  end

  assign tok_o       = tok_q;
  assign match_idx_o = match_idx_q;
  assign free_idx_o  = free_idx_q;

endmodule

// ----- src/tcp_connection_tracker_core.sv -----
// Top level of the TCP connection tracker: input and output registers,
// decision logic and the chain of tct_cell slots. Depends on tct_pkg, tct_cell.
//
//   Channel | Direction | Handshake           | Payload
//   in      | to block  | in_valid_i/in_stall_o   | in_data_i (tct_pkg::in_item_t)
//   out     | from block| out_valid_o/out_stall_i | out_data_o (tct_pkg::out_item_t)
//   cfg     | to block  | cfg_valid_i/cfg_ready_o | cfg_index_i, cfg_data_i
//
// One transaction runs from acceptance to the next acceptance through these steps:
// the search token is launched from start_q, passes through the register of
// every cell, is captured in done_q and is then decided on. The slot write
// lands in the cycle after the decision, alongside the next acceptance. Reset
// clears all slot valid bits at once, with no clearing pass. While an earlier
// result sits stalled in the output register the decision waits; otherwise the
// next transaction is accepted and searched while the result waits.
`include "tcp_connection_tracker_core_defines.svh"

module tcp_connection_tracker_core #(
  parameter int unsigned TABLE_ENTRIES = tct_pkg::TableEntries
) (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         in_valid_i,
  output logic                         in_stall_o,
  input  tct_pkg::in_item_t            in_data_i,
  output logic                         out_valid_o,
  input  logic                         out_stall_i,
  output tct_pkg::out_item_t           out_data_o,
  input  logic                         cfg_valid_i,
  output logic                         cfg_ready_o,
  input  logic [tct_pkg::CfgIdxW-1:0]  cfg_index_i,
  input  logic [7:0]                   cfg_data_i
);

  localparam int unsigned IdxW = $clog2(TABLE_ENTRIES);

  // Configuration registers; writes are always taken.
  logic       grab_en_q;
  logic [7:0] grab_thr_q;

  // Control: busy from acceptance until the decision has been made.
  logic busy_q, start_q, done_q;
  tct_pkg::in_item_t  hdr_q;
  tct_pkg::tok_t      done_tok_q;
  logic [IdxW-1:0]    done_midx_q, done_fidx_q;
  logic               out_valid_q;
  tct_pkg::out_item_t out_q, out_d;
  tct_pkg::wr_t       wr_q, wr_d;
  logic [IdxW-1:0]    wr_idx_q, wr_idx_d;
  logic               in_acc, out_free, decide;
  tct_pkg::tok_t      start_tok;

  // Chain wiring: position 0 is the start token, position N leaves the last cell.
  tct_pkg::tok_t   chain_tok  [TABLE_ENTRIES+1];
  logic [IdxW-1:0] chain_midx [TABLE_ENTRIES+1];
  logic [IdxW-1:0] chain_fidx [TABLE_ENTRIES+1];

  assign cfg_ready_o = 1'b1;
  assign in_stall_o  = busy_q;
  assign in_acc      = in_valid_i && !busy_q;
  assign out_free    = !out_valid_q || !out_stall_i;
  assign decide      = done_q && out_free;
  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_q;

  always_comb begin
    start_tok       = '0;
    start_tok.valid = start_q;
  end

  assign chain_tok[0]  = start_tok;
  assign chain_midx[0] = '0;
  assign chain_fidx[0] = '0;

  for (genvar g = 0; g < TABLE_ENTRIES; g++) begin : g_cell
    tct_cell #(
      .IdxW    (IdxW),
      .CellIdx (g)
    ) u_cell (
      .clk_i       (clk_i),
      .rst_ni      (rst_ni),
      .hdr_i       (hdr_q),
      .tok_i       (chain_tok[g]),
      .match_idx_i (chain_midx[g]),
      .free_idx_i  (chain_fidx[g]),
      .tok_o       (chain_tok[g+1]),
      .match_idx_o (chain_midx[g+1]),
      .free_idx_o  (chain_fidx[g+1]),
      .wr_i        (wr_q),
      .wr_idx_i    (wr_idx_q)
    );
  end

  // Decision on the finished search token. Of the matched slot's contents only its
  // status and ACK count, plus the direction flags, are needed to update the entry.
  always_comb begin
    logic [7:0] fl;
    logic [7:0] st;
    logic [7:0] need, mark, other;
    logic [7:0] cnt;
    logic       is_syn_only, fwd, rev;
    logic [3:0] ev;
    logic       nt;
    fl          = hdr_q.tcp_flags;
    st          = done_tok_q.status;
    cnt         = done_tok_q.ack_count;
    fwd         = done_tok_q.fwd;
    rev         = !fwd && done_tok_q.sa_eq_dst;
    need        = fwd ? tct_pkg::StFinDst : tct_pkg::StFinSrc;
    mark        = fwd ? tct_pkg::StDstDone : tct_pkg::StSrcDone;
    other       = fwd ? tct_pkg::StSrcDone : tct_pkg::StDstDone;
    is_syn_only = fl[tct_pkg::FlagSyn] && !fl[tct_pkg::FlagAck];
    ev          = tct_pkg::EvUpdated;
    nt          = 1'b0;
    out_d       = '0;
    wr_d        = '0;
    wr_idx_d    = done_midx_q;
    wr_d.last_time = hdr_q.timestamp;
    wr_d.fwd_seq   = fwd ? hdr_q.src_seq : hdr_q.dst_seq;
    wr_d.rev_seq   = fwd ? hdr_q.dst_seq : hdr_q.src_seq;

    if (fl[tct_pkg::FlagRst]) begin
      if (!done_tok_q.match_found) begin
        out_d.event_res = tct_pkg::EvIgnored;
      end else begin
        out_d.event_res    = tct_pkg::EvReset;
        out_d.entry_index  = 6'(done_midx_q);
        out_d.notify       = |(st & tct_pkg::StEst);
        out_d.entry_status = st;
        wr_d.valid         = 1'b1;
        wr_d.op            = tct_pkg::WR_REMOVE;
      end
    end else if (!done_tok_q.match_found) begin
      // Untracked packet: maybe add a new entry in the first free slot.
      if (!is_syn_only && !grab_en_q) begin
        out_d.event_res = tct_pkg::EvIgnored;
      end else if (!done_tok_q.free_found) begin
        out_d.event_res = tct_pkg::EvFull;
      end else begin
        st                 = is_syn_only ? tct_pkg::StSyn : tct_pkg::StGrab;
        out_d.event_res    = is_syn_only ? tct_pkg::EvAttempt : tct_pkg::EvGrabbed;
        out_d.entry_index  = 6'(done_fidx_q);
        out_d.entry_status = st;
        wr_idx_d           = done_fidx_q;
        wr_d.valid         = 1'b1;
        wr_d.op            = tct_pkg::WR_ALLOC;
        wr_d.status        = st;
        wr_d.ack_count     = '0;
        wr_d.fwd_seq       = hdr_q.src_seq;
        wr_d.rev_seq       = hdr_q.dst_seq;
      end
    end else if (is_syn_only) begin
      // Repeated SYN on a tracked connection changes nothing.
      out_d.event_res    = tct_pkg::EvUpdated;
      out_d.entry_index  = 6'(done_midx_q);
      out_d.entry_status = st;
    end else begin
      wr_d.valid = 1'b1;
      wr_d.op    = tct_pkg::WR_UPDATE;
      if (fl[tct_pkg::FlagSyn] && fl[tct_pkg::FlagAck]) begin
        if (!done_tok_q.sa_eq_dst) ev = tct_pkg::EvSynAckIn;
        else st = st | tct_pkg::StSynAck;
      end else if (fl[tct_pkg::FlagFin]) begin
        st = st | (fwd ? tct_pkg::StFinSrc : tct_pkg::StFinDst);
      end else if (fl[tct_pkg::FlagAck]) begin
        if (fwd || rev) begin
          if (|(st & need)) begin
            st = st | mark;
            if (|(st & other)) begin
              // Both sides have finished: the entry goes away.
              ev         = tct_pkg::EvFinished;
              nt         = 1'b1;
              wr_d.op    = tct_pkg::WR_REMOVE;
            end
          end
          if (wr_d.op != tct_pkg::WR_REMOVE &&
              !(|(st & tct_pkg::StEst)) && |(st & tct_pkg::StSynAck)) begin
            st = st | tct_pkg::StEst;
            nt = 1'b1;
            ev = tct_pkg::EvEstab;
          end
        end
        if (wr_d.op != tct_pkg::WR_REMOVE && |(st & tct_pkg::StGrab) &&
            cnt < grab_thr_q) begin
          cnt = 8'(cnt + 8'd1);
          if (cnt == grab_thr_q && ev == tct_pkg::EvUpdated) ev = tct_pkg::EvSpotted;
        end
      end
      wr_d.status        = st;
      wr_d.ack_count     = cnt;
      out_d.event_res    = ev;
      out_d.entry_index  = 6'(done_midx_q);
      out_d.notify       = nt;
      out_d.entry_status = st;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      grab_en_q   <= 1'b0;
      grab_thr_q  <= 8'd3;
      busy_q      <= 1'b0;
      start_q     <= 1'b0;
      done_q      <= 1'b0;
      out_valid_q <= 1'b0;
      wr_q        <= '0;
    end else begin
      if (cfg_valid_i) begin
        unique case (cfg_index_i)
          tct_pkg::CfgGrabEnable:    grab_en_q  <= cfg_data_i[0];
          tct_pkg::CfgGrabThreshold: grab_thr_q <= cfg_data_i;
          default: ;
        endcase
      end
      start_q <= in_acc;
      if (in_acc) busy_q <= 1'b1;
      else if (decide) busy_q <= 1'b0;
      if (chain_tok[TABLE_ENTRIES].valid) done_q <= 1'b1;
      else if (decide) done_q <= 1'b0;
      if (decide) out_valid_q <= 1'b1;
      else if (!out_stall_i) out_valid_q <= 1'b0;
      wr_q <= decide ? wr_d : '0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_acc) hdr_q <= in_data_i;
    if (chain_tok[TABLE_ENTRIES].valid) begin
      done_tok_q  <= chain_tok[TABLE_ENTRIES];
      done_midx_q <= chain_midx[TABLE_ENTRIES];
      done_fidx_q <= chain_fidx[TABLE_ENTRIES];
    end
    if (decide) begin
      out_q    <= out_d;
      wr_idx_q <= wr_idx_d;
    end
  end

  `TCT_ASSERT_NEXT(a_busy_after_accept, in_acc, busy_q, "not busy after accept")
  `TCT_ASSERT_SAME(a_done_while_busy, done_q, busy_q, "search done while idle")
  `TCT_ASSERT_NEXT(a_write_follows_decide, decide && wr_d.valid, wr_q.valid,
                   "slot write lost")
  `TCT_ASSERT_SAME(a_event_range, out_valid_q, out_q.event_res <= tct_pkg::EvSpotted,
                   "event code out of range")

endmodule
